[rtl/bmhq_pkg.sv]
// Control word types, codes and microprogram for the binary min-heap queue.
package bmhq_pkg;

  localparam int STEP_W = 4;

  // Microprogram step addresses
  localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] S_DISP   = 4'd1;
  localparam logic [STEP_W-1:0] S_CHKRM  = 4'd2;
  localparam logic [STEP_W-1:0] S_INS    = 4'd3;
  localparam logic [STEP_W-1:0] S_UP_RD  = 4'd4;
  localparam logic [STEP_W-1:0] S_UP_CMP = 4'd5;
  localparam logic [STEP_W-1:0] S_UP_MV  = 4'd6;
  localparam logic [STEP_W-1:0] S_UP_END = 4'd7;
  localparam logic [STEP_W-1:0] S_RM0    = 4'd8;
  localparam logic [STEP_W-1:0] S_RM1    = 4'd9;
  localparam logic [STEP_W-1:0] S_DN_CMP = 4'd10;
  localparam logic [STEP_W-1:0] S_DN_MV  = 4'd11;
  localparam logic [STEP_W-1:0] S_DN_END = 4'd12;
  localparam logic [STEP_W-1:0] S_FIN    = 4'd13;
  localparam logic [STEP_W-1:0] S_OUT    = 4'd14;

  // Request operations and result status codes
  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_REMOVE = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_NOSTART, C_REJECT, C_REMOVE, C_UP_STOP, C_DN_STOP
  } cond_t;

  typedef enum logic [2:0] {
    RA_NONE, RA_PARENT, RA_GRAND, RA_LAST, RA_KIDS_P, RA_KIDS_C, RA_ROOT
  } rd_sel_t;

  typedef enum logic [1:0] {
    W_NONE, W_RDATA, W_HOLD, W_CVAL
  } wr_sel_t;

  typedef enum logic [2:0] {
    P_KEEP, P_HALF, P_NEW, P_ONE, P_CHILD
  } pos_op_t;

  typedef enum logic [1:0] {
    K_KEEP, K_INC, K_DEC
  } cnt_op_t;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] target;
    rd_sel_t           rd_sel;
    wr_sel_t           wr_sel;
    pos_op_t           pos_op;
    cnt_op_t           cnt_op;
    logic              latch;
    logic              set_status;
    logic              load_hold;
    logic              load_child;
    logic              strobe;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{cond: C_ALWAYS, target: S_IDLE, rd_sel: RA_NONE, wr_sel: W_NONE,
          pos_op: P_KEEP, cnt_op: K_KEEP, latch: 1'b0, set_status: 1'b0,
          load_hold: 1'b0, load_child: 1'b0, strobe: 1'b0};
    case (step)
      S_IDLE: begin
        w.cond = C_NOSTART; w.target = S_IDLE; w.latch = 1'b1;
      end
      S_DISP: begin
        w.cond = C_REJECT; w.target = S_FIN; w.set_status = 1'b1;
      end
      S_CHKRM: begin
        w.cond = C_REMOVE; w.target = S_RM0;
      end
      S_INS: begin
        w.cond = C_NEXT; w.pos_op = P_NEW; w.cnt_op = K_INC;
      end
      S_UP_RD: begin
        w.cond = C_NEXT; w.rd_sel = RA_PARENT;
      end
      S_UP_CMP: begin
        w.cond = C_UP_STOP; w.target = S_UP_END;
      end
      S_UP_MV: begin
        // pull parent down into the hole, climb, fetch the next parent
        w.target = S_UP_CMP; w.wr_sel = W_RDATA; w.pos_op = P_HALF;
        w.rd_sel = RA_GRAND;
      end
      S_UP_END: begin
        w.target = S_FIN; w.wr_sel = W_HOLD;
      end
      S_RM0: begin
        w.cond = C_NEXT; w.rd_sel = RA_LAST; w.cnt_op = K_DEC; w.pos_op = P_ONE;
      end
      S_RM1: begin
        w.cond = C_NEXT; w.load_hold = 1'b1; w.rd_sel = RA_KIDS_P;
      end
      S_DN_CMP: begin
        w.cond = C_DN_STOP; w.target = S_DN_END; w.load_child = 1'b1;
      end
      S_DN_MV: begin
        // lift smaller child into the hole, descend, fetch its children
        w.target = S_DN_CMP; w.wr_sel = W_CVAL; w.pos_op = P_CHILD;
        w.rd_sel = RA_KIDS_C;
      end
      S_DN_END: begin
        w.cond = C_NEXT; w.wr_sel = W_HOLD;
      end
      S_FIN: begin
        w.cond = C_NEXT; w.rd_sel = RA_ROOT;
      end
      S_OUT: begin
        w.target = S_IDLE; w.strobe = 1'b1;
      end
      default: begin
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/binary_min_heap_queue_top.sv]
// Binary min-heap priority queue driven by a microprogrammed sequencer.
//
// Raise start with operation and value while busy is low; the request is
// taken at that edge and busy stays high until the result is out. Every
// request gives one result, shown for exactly one cycle with done high;
// the receiver cannot stall it. The time that an insert or a removal takes
// grows with the number of heap levels that the element moves. A dropped
// insert or an ignored remove skips the sift and still gives a result. The
// next request can be taken in the cycle that shows the result. The
// microprogram sifts in a two-step loop around the heap memory, which has a
// registered read port and is written once per level.
module binary_min_heap_queue_top
  import bmhq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] min_value,
  output logic [6:0]         element_count,
  output logic               is_empty,
  output logic [1:0]         status
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam int XW = PW + 1;

  logic [STEP_W-1:0] upc;
  logic [STEP_W-1:0] upc_next;
  ctrl_t             cw;

  logic signed [31:0] heap [0:DEPTH-1];
  logic signed [31:0] rdata_a;
  logic signed [31:0] rdata_b;

  logic [PW-1:0]      count;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      cidx;
  logic signed [31:0] cval;
  logic signed [31:0] hold;
  logic               op;
  logic [1:0]         stat;

  logic [XW-1:0]      addr_a;
  logic [XW-1:0]      addr_b;
  logic [AW-1:0]      slot_a;
  logic [AW-1:0]      slot_b;
  logic [AW-1:0]      slot_w;
  logic               rd_en;

  logic [XW-1:0]      two_p;
  logic [XW-1:0]      n_x;
  logic               has_right;
  logic               take_right;
  logic [PW-1:0]      sel_idx;
  logic signed [31:0] sel_val;
  logic               dn_stop;
  logic               up_stop;
  logic               reject;
  logic               jump;

  assign cw   = ucode(upc);
  assign busy = (upc != S_IDLE);

  // Read address selection; port b reads the address after port a, the right sibling on a children read
  always_comb begin
    rd_en = 1'b1;
    case (cw.rd_sel)
      RA_PARENT: addr_a = {1'b0, pos} >> 1;
      RA_GRAND:  addr_a = {1'b0, pos} >> 2;
      RA_LAST:   addr_a = {1'b0, count};
      RA_KIDS_P: addr_a = {pos, 1'b0};
      RA_KIDS_C: addr_a = {cidx, 1'b0};
      RA_ROOT:   addr_a = XW'(1);
      default: begin
        addr_a = '0;
        rd_en  = 1'b0;
      end
    endcase
    addr_b = addr_a + XW'(1);
  end

  assign slot_a = AW'(addr_a - XW'(1));
  assign slot_b = AW'(addr_b - XW'(1));
  assign slot_w = AW'(pos - PW'(1));

  always_ff @(posedge clk) begin
    if (cw.wr_sel != W_NONE) begin
      case (cw.wr_sel)
        W_RDATA: heap[slot_w] <= rdata_a;
        W_CVAL:  heap[slot_w] <= cval;
        default: heap[slot_w] <= hold;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_a <= heap[slot_a];
      rdata_b <= heap[slot_b];
    end
  end

  // Sift conditions
  assign two_p      = {pos, 1'b0};
  assign n_x        = {1'b0, count};
  assign has_right  = (two_p + XW'(1)) <= n_x;
  assign take_right = has_right && !(rdata_a < rdata_b);
  assign sel_idx    = take_right ? PW'(two_p + XW'(1)) : PW'(two_p);
  assign sel_val    = take_right ? rdata_b : rdata_a;
  assign dn_stop    = (two_p > n_x) || !(sel_val < hold);
  assign up_stop    = (pos == PW'(1)) || !(hold < rdata_a);
  assign reject     = (op == OP_REMOVE) ? (count == '0) : (count == PW'(DEPTH));

  always_comb begin
    case (cw.cond)
      C_NEXT:    jump = 1'b0;
      C_ALWAYS:  jump = 1'b1;
      C_NOSTART: jump = !start;
      C_REJECT:  jump = reject;
      C_REMOVE:  jump = (op == OP_REMOVE);
      C_UP_STOP: jump = up_stop;
      C_DN_STOP: jump = dn_stop;
      default:   jump = 1'b1;
    endcase
    upc_next = jump ? cw.target : upc + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc   <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      upc  <= upc_next;
      done <= cw.strobe;
      case (cw.cnt_op)
        K_INC:   count <= count + PW'(1);
        K_DEC:   count <= count - PW'(1);
        default: count <= count;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cw.latch && start) begin
      op   <= operation;
      hold <= value;
    end else if (cw.load_hold) begin
      hold <= rdata_a;
    end
    if (cw.set_status) begin
      stat <= reject ? ((op == OP_REMOVE) ? ST_EMPTY : ST_FULL) : ST_OK;
    end
    if (cw.load_child) begin
      cidx <= sel_idx;
      cval <= sel_val;
    end
    case (cw.pos_op)
      P_HALF:  pos <= pos >> 1;
      P_NEW:   pos <= count + PW'(1);
      P_ONE:   pos <= PW'(1);
      P_CHILD: pos <= cidx;
      default: pos <= pos;
    endcase
    if (cw.strobe) begin
      min_value     <= (count != '0) ? rdata_a : 32'sd0;
      element_count <= 7'(count);
      is_empty      <= (count == '0);
      status        <= stat;
    end
  end

endmodule

[rtl/bmhq_checker.sv]
// Port-level checker for the binary min-heap queue, bound to the top level.
module bmhq_checker
  import bmhq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               operation,
  input logic signed [31:0] value,
  input logic               done,
  input logic signed [31:0] min_value,
  input logic [6:0]         element_count,
  input logic               is_empty,
  input logic [1:0]         status
);

  // a taken request raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but busy not raised");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (element_count == 7'd0)))
    else $error("empty flag disagrees with count");

  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (min_value == 32'sd0 && status != ST_FULL))
    else $error("empty heap result carries a value or full status");

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 100ps

module testbench
  import bmhq_pkg::*;
();

  localparam int HEAP_DEPTH  = 64;
  localparam int DRAIN_WAIT  = 30;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] min_value;
    logic [6:0]         element_count;
    logic               is_empty;
    logic [1:0]         status;
  } heap_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               operation = OP_INSERT;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] min_value;
  logic [6:0]         element_count;
  logic               is_empty;
  logic [1:0]         status;

  // Shadow heap, 1-based positions
  logic signed [31:0] shadow_heap [1:HEAP_DEPTH];
  int                 shadow_count = 0;

  heap_result_t       pending_results [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 idle_on = 1'b1;

  binary_min_heap_queue_top #(.DEPTH(HEAP_DEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .value        (value),
    .done         (done),
    .min_value    (min_value),
    .element_count(element_count),
    .is_empty     (is_empty),
    .status       (status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binary_min_heap_queue_top: mismatch");
      $finish;
    end
  end

  function automatic void swap_slots(int a, int b);
    logic signed [31:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  // Apply one request to the shadow heap and return the result it must give.
  function automatic heap_result_t heap_apply(logic op, logic signed [31:0] val);
    heap_result_t r;
    int p;
    int c;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (shadow_count >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_count++;
        shadow_heap[shadow_count] = val;
        p = shadow_count;
        while (p > 1 && shadow_heap[p] < shadow_heap[p / 2]) begin
          swap_slots(p, p / 2);
          p = p / 2;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        shadow_heap[1] = shadow_heap[shadow_count];
        shadow_count--;
        p = 1;
        while (shadow_count >= 2 && 2 * p <= shadow_count) begin
          c = 2 * p;
          // equal children: take the right one
          if (c + 1 <= shadow_count && !(shadow_heap[c] < shadow_heap[c + 1]))
            c = c + 1;
          if (shadow_heap[c] < shadow_heap[p]) begin
            swap_slots(p, c);
            p = c;
          end else begin
            break;
          end
        end
      end
    end
    r.min_value     = (shadow_count > 0) ? shadow_heap[1] : 32'sd0;
    r.element_count = shadow_count[6:0];
    r.is_empty      = (shadow_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    heap_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (min_value !== want.min_value) begin
          $error("min_value: expected %0d, actual %0d", want.min_value, min_value);
          mismatch_count++;
        end
        if (element_count !== want.element_count) begin
          $error("element_count: expected %0d, actual %0d", want.element_count,
                 element_count);
          mismatch_count++;
        end
        if (is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", want.is_empty, is_empty);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_request(input logic op, input logic signed [31:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    value     <= val;
    do @(posedge clk); while (!(start && !busy));
    pending_results.push_back(heap_apply(op, val));
  endtask

  // Hold off until every pending result is back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_remove();
    send_request(OP_REMOVE, $urandom());
    send_request(OP_REMOVE, 32'sh80000000);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_REMOVE, 32'sh7FFFFFFF);
    send_request(OP_REMOVE, $urandom());
    drain_results();
  endtask

  task automatic test_extremes();
    send_request(OP_INSERT, 32'sh7FFFFFFF);
    send_request(OP_INSERT, 32'sh80000000);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd1);
    // duplicates: equal to parent and equal children
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, 32'sh80000000);
    send_request(OP_INSERT, 32'sh7FFFFFFF);
    repeat (11) send_request(OP_REMOVE, $urandom());
    drain_results();
  endtask

  task automatic test_full_and_drain();
    idle_on = 1'b0;
    repeat (HEAP_DEPTH) send_request(OP_INSERT, pick_value());
    idle_on = 1'b1;
    send_request(OP_INSERT, 32'sh80000000);
    send_request(OP_INSERT, $urandom());
    send_request(OP_REMOVE, $urandom());
    send_request(OP_INSERT, 32'sh80000000);
    send_request(OP_INSERT, 32'sh7FFFFFFF);
    repeat (HEAP_DEPTH + 2) send_request(OP_REMOVE, $urandom());
    drain_results();
  endtask

  task automatic test_random_mix();
    int insert_pct;
    for (int phase = 0; phase < 20; phase++) begin
      // walk the fill level up and down across phases
      case ($urandom_range(0, 4))
        0: insert_pct = 10;
        1: insert_pct = 35;
        2: insert_pct = 50;
        3: insert_pct = 65;
        default: insert_pct = 90;
      endcase
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0) idle_on = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 99) < insert_pct)
          send_request(OP_INSERT, pick_value());
        else
          send_request(OP_REMOVE, $urandom());
      end
      if (phase % 5 == 4) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_remove();
    test_extremes();
    test_full_and_drain();
    test_random_mix();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("binary_min_heap_queue_top: match");
    end else begin
      $display("binary_min_heap_queue_top: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bmhq_pkg.sv
rtl/binary_min_heap_queue_top.sv
rtl/bmhq_checker.sv
tb/testbench.sv
